// ===== hw/rtl/imm_pkg.sv =====
// Shared types, constants and helpers for the integer matrix multiplier.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int DIM_DEF        = 5;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int PROD_W         = 34;
    localparam int OP_W           = 2;
    localparam int OUT_IDX_W      = 3;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic issue;
        logic first_k;
        logic last_k;
        logic last_item;
    } t_ctl_cmd;

    typedef struct packed {
        logic pipe_en;
    } t_dp_status;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_matrix_multiply.sv =====
// Channel   Direction  Signals
// input     in         i_in_valid, o_in_stall, i_op, i_row, i_col, i_element
// result    out        o_out_valid, i_out_stall, o_out_row, o_out_col,
//                      o_product_value, o_last
//
// Load items produce nothing. A compute item stalls the input until its
// sweep ends, one multiply-accumulate per cycle on the single multiplier
// unless the pipe is frozen. Reset (i_rst_n, synchronous) clears control
// only; operand stores are not cleared. An output stall while a result is
// held freezes the whole read/multiply/accumulate pipe. Top level:
// controller and datapath. Depends on imm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [OP_W-1:0]              i_op,
    input  wire logic [OUT_IDX_W-1:0]         i_row,
    input  wire logic [OUT_IDX_W-1:0]         i_col,
    input  wire logic signed [ELEM_WIDTH-1:0] i_element,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [OUT_IDX_W-1:0]              o_out_row,
    output logic [OUT_IDX_W-1:0]              o_out_col,
    output logic signed [PROD_W-1:0]          o_product_value,
    output logic                              o_last
);

    localparam int AW = idx_w(DIM * DIM);
    localparam int IW = idx_w(DIM);

    t_ctl_cmd      cmd;
    t_dp_status    status;
    logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic [IW-1:0] row_idx, col_idx;

    imm_controller #(
        .DIM (DIM)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr),
        .o_row_idx   (row_idx),
        .o_col_idx   (col_idx)
    );

    imm_datapath #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (i_element),
        .i_rd_a_addr     (rd_a_addr),
        .i_rd_b_addr     (rd_b_addr),
        .i_row_idx       (row_idx),
        .i_col_idx       (col_idx),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/imm_datapath.sv =====
// Datapath: operand stores A and B, read stage, multiplier, accumulator
// and output register. Depends on imm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imm_datapath
    import imm_pkg::*;
#(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_ctl_cmd                           i_cmd,
    input  wire logic [idx_w(DIM*DIM)-1:0]          i_wr_addr,
    input  wire logic signed [ELEM_WIDTH-1:0]       i_wr_data,
    input  wire logic [idx_w(DIM*DIM)-1:0]          i_rd_a_addr,
    input  wire logic [idx_w(DIM*DIM)-1:0]          i_rd_b_addr,
    input  wire logic [idx_w(DIM)-1:0]              i_row_idx,
    input  wire logic [idx_w(DIM)-1:0]              i_col_idx,
    input  wire logic                               i_out_stall,
    output t_dp_status                              o_status,
    output logic                                    o_out_valid,
    output logic [OUT_IDX_W-1:0]                    o_out_row,
    output logic [OUT_IDX_W-1:0]                    o_out_col,
    output logic signed [PROD_W-1:0]                o_product_value,
    output logic                                    o_last
);

    localparam int CELLS = DIM * DIM;
    localparam int IW    = idx_w(DIM);
    localparam int PW    = 2 * ELEM_WIDTH;

    typedef struct packed {
        logic valid;
        logic first_k;
        logic last_k;
        logic last_item;
    } t_tag;

    logic signed [ELEM_WIDTH-1:0] r_mem_a [CELLS];
    logic signed [ELEM_WIDTH-1:0] r_mem_b [CELLS];

    logic                         pipe_en;
    t_tag                         r_s1_tag, r_s2_tag;
    logic [IW-1:0]                r_s1_row, r_s1_col, r_s2_row, r_s2_col;
    logic signed [ELEM_WIDTH-1:0] r_a_q, r_b_q;
    logic signed [PW-1:0]         r_prod;
    logic signed [PROD_W-1:0]     prod_ext, n_acc, r_acc;
    logic                         r_out_valid, r_out_last;
    logic [IW-1:0]                r_out_row, r_out_col;
    logic signed [PROD_W-1:0]     r_out_value;

    assign pipe_en          = !(r_out_valid && i_out_stall);
    assign o_status.pipe_en = pipe_en;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_q    <= r_mem_a[i_rd_a_addr];
            r_b_q    <= r_mem_b[i_rd_b_addr];
            r_s1_row <= i_row_idx;
            r_s1_col <= i_col_idx;
            r_prod   <= r_a_q * r_b_q;
            r_s2_row <= r_s1_row;
            r_s2_col <= r_s1_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag    <= '0;
            r_s2_tag    <= '0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_tag    <= '{valid:     i_cmd.issue,
                             first_k:   i_cmd.first_k,
                             last_k:    i_cmd.last_k,
                             last_item: i_cmd.last_item};
            r_s2_tag    <= r_s1_tag;
            r_out_valid <= r_s2_tag.valid && r_s2_tag.last_k;
        end
    end

    // modulo 2^PROD_W accumulation
    assign prod_ext = PROD_W'(r_prod);
    assign n_acc    = r_s2_tag.first_k ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_s2_tag.valid) begin
            r_acc <= n_acc;
            if (r_s2_tag.last_k) begin
                r_out_value <= n_acc;
                r_out_row   <= r_s2_row;
                r_out_col   <= r_s2_col;
                r_out_last  <= r_s2_tag.last_item;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = OUT_IDX_W'(r_out_row);
    assign o_out_col       = OUT_IDX_W'(r_out_col);
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

`ifndef SYNTHESIS
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_value)))
        else $error("stalled result lost or changed");

    a_last_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_row == IW'(DIM-1) && r_out_col == IW'(DIM-1)))
        else $error("last flag on wrong product element");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/imm_controller.sv =====
// Controller: decodes input items, sequences the row, column and inner
// product counters over the operand stores. Depends on imm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imm_controller
    import imm_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [OP_W-1:0]             i_op,
    input  wire logic [OUT_IDX_W-1:0]        i_row,
    input  wire logic [OUT_IDX_W-1:0]        i_col,
    input  wire t_dp_status                  i_status,
    output logic                             o_in_stall,
    output t_ctl_cmd                         o_cmd,
    output logic [idx_w(DIM*DIM)-1:0]        o_wr_addr,
    output logic [idx_w(DIM*DIM)-1:0]        o_rd_a_addr,
    output logic [idx_w(DIM*DIM)-1:0]        o_rd_b_addr,
    output logic [idx_w(DIM)-1:0]            o_row_idx,
    output logic [idx_w(DIM)-1:0]            o_col_idx
);

    localparam int AW = idx_w(DIM * DIM);
    localparam int IW = idx_w(DIM);
    localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic          accept, in_range, issue, step, last_k, last_item;

    assign accept    = i_in_valid && !o_in_stall;
    assign in_range  = (int'(i_row) < DIM) && (int'(i_col) < DIM);
    assign issue     = (r_state == ST_RUN);
    assign step      = issue && i_status.pipe_en;
    assign last_k    = (r_k == IDX_LAST);
    assign last_item = last_k && (r_i == IDX_LAST) && (r_j == IDX_LAST);

    assign o_in_stall     = (r_state == ST_RUN);
    assign o_cmd.wr_a     = accept && in_range && (i_op == OP_LOAD_A);
    assign o_cmd.wr_b     = accept && in_range && (i_op == OP_LOAD_B);
    assign o_cmd.issue    = issue;
    assign o_cmd.first_k  = (r_k == '0);
    assign o_cmd.last_k   = last_k;
    assign o_cmd.last_item = last_item;

    assign o_wr_addr   = AW'(int'(i_row) * DIM + int'(i_col));
    assign o_rd_a_addr = AW'(int'(r_i) * DIM + int'(r_k));
    assign o_rd_b_addr = AW'(int'(r_k) * DIM + int'(r_j));
    assign o_row_idx   = r_i;
    assign o_col_idx   = r_j;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_op == OP_COMPUTE) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (step) begin
                    if (last_k) begin
                        n_k = '0;
                        if (r_j == IDX_LAST) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                    if (last_item) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

`ifndef SYNTHESIS
    a_run_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last_item) |=> (r_state == ST_IDLE))
        else $error("sequencer did not finish after final product term");

    a_run_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && accept && i_op == OP_COMPUTE) |=>
            (r_state == ST_RUN && r_i == '0 && r_j == '0 && r_k == '0))
        else $error("compute item did not start a fresh sweep");
`endif

endmodule

`default_nettype wire

// ===== tb/integer_matrix_multiply_test.sv =====
// Testbench for integer_matrix_multiply: directed and random load/compute items with
// random idling on both channels, results checked by a product scoreboard class.
// Depends on imm_pkg and the integer_matrix_multiply RTL.
`timescale 1ns / 1ps

import imm_pkg::*;

typedef struct packed {
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic signed [PROD_W-1:0] value;
    logic                     last;
} product_t;

class product_scoreboard;
    logic signed [ELEM_WIDTH_DEF-1:0] mat_a [DIM_DEF][DIM_DEF];
    logic signed [ELEM_WIDTH_DEF-1:0] mat_b [DIM_DEF][DIM_DEF];
    product_t expected_products [$];
    int       mismatches;
    int       products_checked;

    function new();
        mismatches       = 0;
        products_checked = 0;
        foreach (mat_a[i, j]) begin
            mat_a[i][j] = '0;
            mat_b[i][j] = '0;
        end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [OUT_IDX_W-1:0] r,
                            logic [OUT_IDX_W-1:0] c,
                            logic signed [ELEM_WIDTH_DEF-1:0] e);
        longint   acc;
        product_t p;
        if (op == OP_LOAD_A || op == OP_LOAD_B) begin
            if (r < DIM_DEF && c < DIM_DEF) begin
                if (op == OP_LOAD_A)
                    mat_a[r][c] = e;
                else
                    mat_b[r][c] = e;
            end
        end else if (op == OP_COMPUTE) begin
            for (int i = 0; i < DIM_DEF; i++) begin
                for (int j = 0; j < DIM_DEF; j++) begin
                    acc = 0;
                    for (int k = 0; k < DIM_DEF; k++)
                        acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
                    p.row   = OUT_IDX_W'(i);
                    p.col   = OUT_IDX_W'(j);
                    p.value = acc[PROD_W-1:0];
                    p.last  = (i == DIM_DEF - 1) && (j == DIM_DEF - 1);
                    expected_products.push_back(p);
                end
            end
        end
    endfunction

    function void check_product(product_t got);
        product_t want;
        if (expected_products.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected product: row %0d col %0d value %0d last %0b",
                         got.row, got.col, got.value, got.last);
            return;
        end
        want = expected_products.pop_front();
        products_checked++;
        if (got.row !== want.row || got.col !== want.col ||
            got.value !== want.value || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"product mismatch: expected row %0d col %0d value %0d last %0b,",
                          " got row %0d col %0d value %0d last %0b"},
                         want.row, want.col, want.value, want.last,
                         got.row, got.col, got.value, got.last);
        end
    endfunction

    function int pending();
        return expected_products.size();
    endfunction
endclass

module integer_matrix_multiply_test;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 180;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = DIM_DEF * DIM_DEF * DIM_DEF + DIM_DEF + 8;
    localparam int IDLE_LIMIT      = 4 * (HOLD_OFF_CYCLES + DRAIN_CYCLES + 20 * DIM_DEF);
    localparam logic signed [ELEM_WIDTH_DEF-1:0] ELEM_MIN =
        {1'b1, {(ELEM_WIDTH_DEF-1){1'b0}}};
    localparam logic signed [ELEM_WIDTH_DEF-1:0] ELEM_MAX =
        {1'b0, {(ELEM_WIDTH_DEF-1){1'b1}}};

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [OP_W-1:0]                  i_op;
    logic [OUT_IDX_W-1:0]             i_row;
    logic [OUT_IDX_W-1:0]             i_col;
    logic signed [ELEM_WIDTH_DEF-1:0] i_element;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic [OUT_IDX_W-1:0]             o_out_row;
    logic [OUT_IDX_W-1:0]             o_out_col;
    logic signed [PROD_W-1:0]         o_product_value;
    logic                             o_last;

    product_scoreboard scoreboard;
    int  in_wait_max;
    int  out_wait_max;
    bit  hold_off_req;
    int  items_done;
    int  ignored_done;
    int  computes_done;

    integer_matrix_multiply u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_element       (i_element),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [ELEM_WIDTH_DEF-1:0] draw_element();
        logic signed [ELEM_WIDTH_DEF-1:0] e;
        case ($urandom_range(0, 3))
            0: e = $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
            1: e = ELEM_WIDTH_DEF'($signed($urandom_range(0, 16)) - 8);
            default: e = ELEM_WIDTH_DEF'($urandom);
        endcase
        return e;
    endfunction

    // entered and left just after a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [OUT_IDX_W-1:0] r,
                             input logic [OUT_IDX_W-1:0] c,
                             input logic signed [ELEM_WIDTH_DEF-1:0] e);
        int gap;
        gap = $urandom_range(0, in_wait_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_row      <= r;
        i_col      <= c;
        i_element  <= e;
        do @(posedge i_clk); while (o_in_stall);
        scoreboard.note_item(op, r, c, e);
        if (op == OP_COMPUTE)
            computes_done++;
        if (op == OP_COMPUTE ||
            ((op == OP_LOAD_A || op == OP_LOAD_B) && r < DIM_DEF && c < DIM_DEF))
            items_done++;
        else
            ignored_done++;
        @(negedge i_clk);
    endtask

    // result side: random hold before each item, one long hold-off on request
    initial begin : result_sink
        int       hold;
        product_t got;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold         = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                hold = $urandom_range(0, out_wait_max);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.row   = o_out_row;
            got.col   = o_out_col;
            got.value = o_product_value;
            got.last  = o_last;
            scoreboard.check_product(got);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int  pick;
        int  phase_left;
        int  line;
        bit  pressure_done;
        scoreboard    = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_LOAD_A;
        i_row         = '0;
        i_col         = '0;
        i_element     = '0;
        hold_off_req  = 1'b0;
        in_wait_max   = 0;
        out_wait_max  = 19;
        items_done    = 0;
        ignored_done  = 0;
        computes_done = 0;
        pressure_done = 1'b0;
        phase_left    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both stores at the most negative value: largest positive sums
        for (int r = 0; r < DIM_DEF; r++)
            for (int c = 0; c < DIM_DEF; c++)
                send_item(OP_LOAD_A, OUT_IDX_W'(r), OUT_IDX_W'(c), ELEM_MIN);
        for (int r = 0; r < DIM_DEF; r++)
            for (int c = 0; c < DIM_DEF; c++)
                send_item(OP_LOAD_B, OUT_IDX_W'(r), OUT_IDX_W'(c), ELEM_MIN);
        send_item(OP_COMPUTE, '0, '0, '0);
        // column 0 of B at the maximum: most negative sums
        for (int r = 0; r < DIM_DEF; r++)
            send_item(OP_LOAD_B, OUT_IDX_W'(r), '0, ELEM_MAX);
        in_wait_max = 19;
        send_item(OP_LOAD_A, 3'd5, 3'd0, ELEM_MAX);
        send_item(OP_LOAD_B, 3'd2, 3'd7, 16'sd1);
        send_item(OP_LOAD_A, 3'd7, 3'd7, 16'sd0);
        send_item(OP_UNUSED, 3'd1, 3'd1, 16'sh5a5a);
        send_item(OP_COMPUTE, 3'd7, 3'd7, -16'sd1);

        while (items_done + ignored_done < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                in_wait_max  = ($urandom_range(0, 2) == 0) ? 0 : 19;
                out_wait_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
                phase_left   = $urandom_range(15, 40);
            end
            phase_left--;
            if (!pressure_done && items_done + ignored_done > RANDOM_ITEMS / 2) begin
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
                send_item(OP_COMPUTE, OUT_IDX_W'($urandom), OUT_IDX_W'($urandom),
                          ELEM_WIDTH_DEF'($urandom));
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(OP_COMPUTE, OUT_IDX_W'($urandom), OUT_IDX_W'($urandom),
                          ELEM_WIDTH_DEF'($urandom));
            end else if (pick < 9) begin
                // refill one row or column of one operand
                line = $urandom_range(0, DIM_DEF - 1);
                for (int k = 0; k < DIM_DEF; k++) begin
                    if (pick < 7)
                        send_item(OP_LOAD_A, OUT_IDX_W'(line), OUT_IDX_W'(k),
                                  draw_element());
                    else
                        send_item(OP_LOAD_B, OUT_IDX_W'(k), OUT_IDX_W'(line),
                                  draw_element());
                end
            end else if (pick < 13) begin
                send_item(OP_UNUSED, OUT_IDX_W'($urandom), OUT_IDX_W'($urandom),
                          ELEM_WIDTH_DEF'($urandom));
            end else if (pick < 18) begin
                send_item($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                          OUT_IDX_W'($urandom_range(DIM_DEF, 7)), OUT_IDX_W'($urandom),
                          draw_element());
            end else if (pick < 22) begin
                send_item($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                          OUT_IDX_W'($urandom_range(0, DIM_DEF - 1)),
                          OUT_IDX_W'($urandom_range(DIM_DEF, 7)),
                          draw_element());
            end else begin
                send_item($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                          OUT_IDX_W'($urandom_range(0, DIM_DEF - 1)),
                          OUT_IDX_W'($urandom_range(0, DIM_DEF - 1)),
                          draw_element());
            end
        end
        send_item(OP_COMPUTE, '0, '0, '0);
        i_in_valid <= 1'b0;

        while (scoreboard.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d loads and computes (%0d of them computes) and %0d ignored items",
                 items_done, computes_done, ignored_done);
        $display("%0d product elements checked, %0d mismatches",
                 scoreboard.products_checked, scoreboard.mismatches);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
